// ----- design/bcc2d_pkg.sv -----
// shared types and constants for the 2d barycentric coordinate pipeline
// no dependencies
package bcc2d_pkg;

    // output weight width, signed fixed point
    localparam int WEIGHT_BITS = 20;

    typedef logic signed [WEIGHT_BITS-1:0] weight_t;

endpackage

// ----- design/barycentric_coordinates_2d.sv -----
// Fully pipelined 2d barycentric coordinates. One request is accepted every cycle
// while the output side takes results. Most of the pipeline stages belong to two
// restoring dividers, one quotient bit per stage, that share one divisor. The weights
// follow from the signed crosses ev = e2 x e1, ew = e0 x e2 and den = e0 x e1, with
// v = ev/den and w = ew/den. The quotients are truncated toward zero with FRAC_BITS
// fraction bits, and u = 1 - v - w. The three weights then saturate to 20 bits. When
// den is zero, degenerate is set and all weights read zero. The whole pipeline stalls
// while a finished result waits.
// depends on bcc2d_pkg
module barycentric_coordinates_2d #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [COORD_BITS-1:0] s_px,
    input  logic signed [COORD_BITS-1:0] s_py,
    input  logic signed [COORD_BITS-1:0] s_ax,
    input  logic signed [COORD_BITS-1:0] s_ay,
    input  logic signed [COORD_BITS-1:0] s_bx,
    input  logic signed [COORD_BITS-1:0] s_by,
    input  logic signed [COORD_BITS-1:0] s_cx,
    input  logic signed [COORD_BITS-1:0] s_cy,
    output logic                         m_valid,
    input  logic                         m_ready,
    output bcc2d_pkg::weight_t           m_weight_u,
    output bcc2d_pkg::weight_t           m_weight_v,
    output bcc2d_pkg::weight_t           m_weight_w,
    output logic                         m_degenerate
);
    import bcc2d_pkg::*;

    localparam int DB = COORD_BITS + 1;       // edge vector width
    localparam int PB = 2 * DB;               // product width
    localparam int CB = PB + 1;               // cross product width
    localparam int MB = PB;                   // cross magnitude width
    localparam int QB = MB + FRAC_BITS;       // quotient bits, one per divider stage
    localparam int UB = QB + 3;               // width of u before saturation
    localparam int NSTG = QB + 5;             // valid bits for every stage

    localparam logic signed [UB-1:0] W_MAX = (UB'(1) <<< (WEIGHT_BITS - 1)) - UB'(1);
    localparam logic signed [UB-1:0] W_MIN = -(UB'(1) <<< (WEIGHT_BITS - 1));
    localparam logic signed [UB-1:0] ONE   = UB'(1) <<< FRAC_BITS;

    logic            adv;
    logic [NSTG-1:0] vld_reg;

    // whole pipe moves unless the result register is held
    assign adv     = !vld_reg[NSTG-1] || m_ready;
    assign s_ready = adv;
    assign m_valid = vld_reg[NSTG-1];

    // valid bits travel with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NSTG-2:0], s_valid};
        end
    end

    // stage 1: edge vectors relative to a
    logic signed [DB-1:0] e0x_reg, e0y_reg, e1x_reg, e1y_reg, e2x_reg, e2y_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            e0x_reg <= DB'(s_bx) - DB'(s_ax);
            e0y_reg <= DB'(s_by) - DB'(s_ay);
            e1x_reg <= DB'(s_cx) - DB'(s_ax);
            e1y_reg <= DB'(s_cy) - DB'(s_ay);
            e2x_reg <= DB'(s_px) - DB'(s_ax);
            e2y_reg <= DB'(s_py) - DB'(s_ay);
        end
    end

    // stage 2: six cross product terms
    logic signed [PB-1:0] pv0_reg, pv1_reg, pw0_reg, pw1_reg, pd0_reg, pd1_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            pv0_reg <= PB'(e2x_reg) * PB'(e1y_reg);
            pv1_reg <= PB'(e2y_reg) * PB'(e1x_reg);
            pw0_reg <= PB'(e0x_reg) * PB'(e2y_reg);
            pw1_reg <= PB'(e0y_reg) * PB'(e2x_reg);
            pd0_reg <= PB'(e0x_reg) * PB'(e1y_reg);
            pd1_reg <= PB'(e0y_reg) * PB'(e1x_reg);
        end
    end

    // stage 3: the three crosses
    logic signed [CB-1:0] xv_reg, xw_reg, xd_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            xv_reg <= CB'(pv0_reg) - CB'(pv1_reg);
            xw_reg <= CB'(pw0_reg) - CB'(pw1_reg);
            xd_reg <= CB'(pd0_reg) - CB'(pd1_reg);
        end
    end

    // divider stage registers, index 0 loaded by stage 4
    logic [MB-1:0] num_v_reg [0:QB];
    logic [MB-1:0] num_w_reg [0:QB];
    logic [MB-1:0] dvs_reg   [0:QB];
    logic [MB-1:0] rem_v_reg [0:QB];
    logic [MB-1:0] rem_w_reg [0:QB];
    logic [QB-1:0] quo_v_reg [0:QB];
    logic [QB-1:0] quo_w_reg [0:QB];
    logic          neg_v_reg [0:QB];
    logic          neg_w_reg [0:QB];
    logic          dgn_reg   [0:QB];

    logic signed [CB-1:0] xv_abs, xw_abs, xd_abs;

    assign xv_abs = xv_reg[CB-1] ? -xv_reg : xv_reg;
    assign xw_abs = xw_reg[CB-1] ? -xw_reg : xw_reg;
    assign xd_abs = xd_reg[CB-1] ? -xd_reg : xd_reg;

    // stage 4: magnitudes, result signs and degenerate flag
    always_ff @(posedge aclk) begin
        if (adv) begin
            num_v_reg[0] <= xv_abs[MB-1:0];
            num_w_reg[0] <= xw_abs[MB-1:0];
            dvs_reg[0]   <= xd_abs[MB-1:0];
            rem_v_reg[0] <= '0;
            rem_w_reg[0] <= '0;
            quo_v_reg[0] <= '0;
            quo_w_reg[0] <= '0;
            neg_v_reg[0] <= xv_reg[CB-1] ^ xd_reg[CB-1];
            neg_w_reg[0] <= xw_reg[CB-1] ^ xd_reg[CB-1];
            dgn_reg[0]   <= (xd_reg == '0);
        end
    end

    // restoring division, one quotient bit per stage for both weights
    for (genvar k = 0; k < QB; k++) begin : g_div
        logic          bit_v, bit_w;
        logic [MB:0]   sh_v, sh_w;
        logic          ge_v, ge_w;
        logic [MB:0]   sub_v, sub_w;

        if (k < MB) begin : g_num
            assign bit_v = num_v_reg[k][MB-1-k];
            assign bit_w = num_w_reg[k][MB-1-k];
        end else begin : g_frac
            assign bit_v = 1'b0;
            assign bit_w = 1'b0;
        end

        assign sh_v  = {rem_v_reg[k], bit_v};
        assign sh_w  = {rem_w_reg[k], bit_w};
        assign ge_v  = sh_v >= {1'b0, dvs_reg[k]};
        assign ge_w  = sh_w >= {1'b0, dvs_reg[k]};
        assign sub_v = sh_v - {1'b0, dvs_reg[k]};
        assign sub_w = sh_w - {1'b0, dvs_reg[k]};

        always_ff @(posedge aclk) begin
            if (adv) begin
                num_v_reg[k+1] <= num_v_reg[k];
                num_w_reg[k+1] <= num_w_reg[k];
                dvs_reg[k+1]   <= dvs_reg[k];
                rem_v_reg[k+1] <= ge_v ? sub_v[MB-1:0] : sh_v[MB-1:0];
                rem_w_reg[k+1] <= ge_w ? sub_w[MB-1:0] : sh_w[MB-1:0];
                quo_v_reg[k+1] <= {quo_v_reg[k][QB-2:0], ge_v};
                quo_w_reg[k+1] <= {quo_w_reg[k][QB-2:0], ge_w};
                neg_v_reg[k+1] <= neg_v_reg[k];
                neg_w_reg[k+1] <= neg_w_reg[k];
                dgn_reg[k+1]   <= dgn_reg[k];
            end
        end
    end

    // final stage: signs, u, saturation
    logic signed [UB-1:0] v_full, w_full, u_full;
    weight_t              u_sat, v_sat, w_sat;

    assign v_full = neg_v_reg[QB] ? -$signed(UB'(quo_v_reg[QB])) : $signed(UB'(quo_v_reg[QB]));
    assign w_full = neg_w_reg[QB] ? -$signed(UB'(quo_w_reg[QB])) : $signed(UB'(quo_w_reg[QB]));
    assign u_full = ONE - v_full - w_full;

    assign u_sat = (u_full > W_MAX) ? W_MAX[WEIGHT_BITS-1:0] :
                   (u_full < W_MIN) ? W_MIN[WEIGHT_BITS-1:0] : u_full[WEIGHT_BITS-1:0];
    assign v_sat = (v_full > W_MAX) ? W_MAX[WEIGHT_BITS-1:0] :
                   (v_full < W_MIN) ? W_MIN[WEIGHT_BITS-1:0] : v_full[WEIGHT_BITS-1:0];
    assign w_sat = (w_full > W_MAX) ? W_MAX[WEIGHT_BITS-1:0] :
                   (w_full < W_MIN) ? W_MIN[WEIGHT_BITS-1:0] : w_full[WEIGHT_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_weight_u   <= dgn_reg[QB] ? '0 : u_sat;
            m_weight_v   <= dgn_reg[QB] ? '0 : v_sat;
            m_weight_w   <= dgn_reg[QB] ? '0 : w_sat;
            m_degenerate <= dgn_reg[QB];
        end
    end

endmodule
